// ===== src/npc_pkg.sv =====
package npc_pkg;

    localparam int PALETTE_DEPTH = 128;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int CFG_W         = 8;
    localparam int DIST_W        = 20;
    localparam int INDEX_W       = 7;

    // redmean weights, sized for 8-bit channels
    localparam int WEIGHT_W = 10;
    localparam logic [WEIGHT_W-1:0] RED_BIAS   = 10'd512;
    localparam logic [WEIGHT_W-1:0] BLUE_BIAS  = 10'd767;
    localparam int                  GREEN_SHIFT = 2;
    localparam int                  WEIGHT_SHIFT = 8;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // travels alongside each palette entry through the distance pipeline
    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

// ===== src/npc_palette_ram.sv =====
module npc_palette_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/npc_distance_unit.sv =====
module npc_distance_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  npc_pkg::t_tag               i_tag,
    input  logic [npc_pkg::COLOR_W-1:0] i_color_a,
    input  logic [npc_pkg::COLOR_W-1:0] i_color_b,
    output logic                        o_valid,
    output npc_pkg::t_tag               o_tag,
    output logic [npc_pkg::DIST_W-1:0]  o_dist
);
    import npc_pkg::*;

    localparam int SQ_W   = 2 * CHAN_W;
    localparam int PROD_W = WEIGHT_W + SQ_W;

    logic [3:0] r_valid;
    t_tag       r_tag [4];

    // stage 1: channel differences and weights
    logic [CHAN_W-1:0]   r_dr, r_dg, r_db;
    logic [WEIGHT_W-1:0] r_wr1, r_wb1;
    // stage 2: squares
    logic [SQ_W-1:0]     r_dr2, r_dg2, r_db2;
    logic [WEIGHT_W-1:0] r_wr2, r_wb2;
    // stage 3: weighted terms
    logic [PROD_W-1:0]   r_tr, r_tb;
    logic [SQ_W+GREEN_SHIFT-1:0] r_tg;
    // stage 4: sum
    logic [DIST_W-1:0]   r_dist;

    logic [CHAN_W-1:0] ra, ga, ba, rb, gb, bb;
    logic [CHAN_W:0]   rsum;
    logic [CHAN_W-1:0] rmean;

    always_comb begin
        ra    = i_color_a[3*CHAN_W-1:2*CHAN_W];
        ga    = i_color_a[2*CHAN_W-1:CHAN_W];
        ba    = i_color_a[CHAN_W-1:0];
        rb    = i_color_b[3*CHAN_W-1:2*CHAN_W];
        gb    = i_color_b[2*CHAN_W-1:CHAN_W];
        bb    = i_color_b[CHAN_W-1:0];
        rsum  = {1'b0, ra} + {1'b0, rb};
        rmean = rsum[CHAN_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        r_tag[3] <= r_tag[2];

        r_dr  <= (ra > rb) ? ra - rb : rb - ra;
        r_dg  <= (ga > gb) ? ga - gb : gb - ga;
        r_db  <= (ba > bb) ? ba - bb : bb - ba;
        r_wr1 <= RED_BIAS + {{(WEIGHT_W-CHAN_W){1'b0}}, rmean};
        r_wb1 <= BLUE_BIAS - {{(WEIGHT_W-CHAN_W){1'b0}}, rmean};

        r_dr2 <= r_dr * r_dr;
        r_dg2 <= r_dg * r_dg;
        r_db2 <= r_db * r_db;
        r_wr2 <= r_wr1;
        r_wb2 <= r_wb1;

        r_tr <= {{SQ_W{1'b0}}, r_wr2} * {{WEIGHT_W{1'b0}}, r_dr2};
        r_tb <= {{SQ_W{1'b0}}, r_wb2} * {{WEIGHT_W{1'b0}}, r_db2};
        r_tg <= {r_dg2, {GREEN_SHIFT{1'b0}}};

        r_dist <= {{(DIST_W-(PROD_W-WEIGHT_SHIFT)){1'b0}}, r_tr[PROD_W-1:WEIGHT_SHIFT]}
                + {{(DIST_W-(PROD_W-WEIGHT_SHIFT)){1'b0}}, r_tb[PROD_W-1:WEIGHT_SHIFT]}
                + {{(DIST_W-(SQ_W+GREEN_SHIFT)){1'b0}}, r_tg};
    end

    assign o_valid = r_valid[3];
    assign o_tag   = r_tag[3];
    assign o_dist  = r_dist;

endmodule

// ===== src/nearest_palette_color_redmean.sv =====
// nearest palette colour search, redmean distance, one shared distance pipeline
// load item: no result, loads can follow back to back
// query item: one entry read per cycle, then the read stage and distance pipe drain;
//   the next item can be taken in the same cycle as the result is shown
// empty palette query: goes straight to the result with no scan; the block takes no item until a query ends
// synchronous active-low reset clears control and entries_in_use; palette is not cleared
module nearest_palette_color_redmean (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [npc_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [npc_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [npc_pkg::COLOR_W-1:0] i_color_value,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [npc_pkg::INDEX_W-1:0] o_best_index,
    output logic [npc_pkg::DIST_W-1:0]  o_best_distance,
    output logic                        o_palette_empty
);
    import npc_pkg::*;

    // control state
    t_state r_state, n_state;
    logic [CFG_W-1:0]   r_entries;      // entries_in_use register
    logic [CNT_W-1:0]   r_count;        // entries searched by this query, saturated
    logic [CNT_W-1:0]   r_issue_cnt;    // next palette entry to read
    logic [COLOR_W-1:0] r_query;        // colour being matched
    logic               r_empty;

    // running best
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;

    // output register
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_empty;

    // read stage tag, lines up with the registered ram data
    logic r_rd_valid;
    t_tag r_rd_tag;

    logic               in_accept;
    logic               issue;
    logic               is_load;
    logic               is_query;
    logic               out_free;
    logic [CNT_W-1:0]   sat_count;
    logic [CNT_W-1:0]   last_cnt;
    logic [COLOR_W-1:0] rd_data;
    t_tag               issue_tag;
    logic               dist_valid;
    t_tag               dist_tag;
    logic [DIST_W-1:0]  dist_val;

    assign in_accept = i_in_valid && o_in_ready;
    assign is_load   = in_accept && (t_cmd'(i_command) == CMD_LOAD);
    assign is_query  = in_accept && (t_cmd'(i_command) == CMD_QUERY);
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_cnt  = r_count - 1'b1;

    // counts above the palette depth saturate
    always_comb begin
        if ({{(32-CFG_W){1'b0}}, r_entries} > PALETTE_DEPTH) begin
            sat_count = CNT_W'(PALETTE_DEPTH);
        end else begin
            sat_count = CNT_W'(r_entries);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_query) begin
                    n_state = (sat_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issue_cnt == last_cnt) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dist_valid && dist_tag.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready    = 1'b0;
        issue         = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_SCAN:  issue      = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  ;
            default:  ;
        endcase
    end

    assign issue_tag.last = (r_issue_cnt == last_cnt);
    assign issue_tag.idx  = r_issue_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entries   <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= issue;
            if (i_cfg_we) begin
                r_entries <= i_cfg_data;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_tag <= issue_tag;
        if (is_query) begin
            r_query     <= i_color_value;
            r_count     <= sat_count;
            r_issue_cnt <= '0;
            r_empty     <= (sat_count == '0);
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (issue) begin
            r_issue_cnt <= r_issue_cnt + 1'b1;
        end
        // entry zero seeds the best, later entries replace it only when strictly nearer
        if (dist_valid && (dist_tag.idx == '0 || dist_val < r_best_dist)) begin
            r_best_idx  <= dist_tag.idx;
            r_best_dist <= dist_val;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_idx   <= INDEX_W'(r_best_idx);
            r_out_dist  <= r_best_dist;
            r_out_empty <= r_empty;
        end
    end

    npc_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .WIDTH (COLOR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (is_load),
        .i_waddr (i_entry_index),
        .i_wdata (i_color_value),
        .i_raddr (issue_tag.idx),
        .o_rdata (rd_data)
    );

    npc_distance_unit u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_rd_valid),
        .i_tag     (r_rd_tag),
        .i_color_a (r_query),
        .i_color_b (rd_data),
        .o_valid   (dist_valid),
        .o_tag     (dist_tag),
        .o_dist    (dist_val)
    );

    assign o_out_valid     = r_out_valid;
    assign o_best_index    = r_out_idx;
    assign o_best_distance = r_out_dist;
    assign o_palette_empty = r_out_empty;

    // the last entry of a scan only leaves the pipe once issuing has stopped
    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_valid && dist_tag.last |-> r_state == ST_DRAIN)
        else $error("last distance outside drain");

    // issue counter never passes the searched count
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_issue_cnt < r_count)
        else $error("issue counter overrun");

    // an empty palette reports index and distance zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_palette_empty |-> o_best_index == '0 && o_best_distance == '0)
        else $error("empty result not zero");

    // no item is accepted while a query is being worked
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_DRAIN) |-> !o_in_ready && r_count != '0)
        else $error("accepting while busy");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    // redmean weights, kept apart from the block's own copies
    localparam int unsigned RED_WEIGHT  = 512;
    localparam int unsigned BLUE_WEIGHT = 767;
    localparam int unsigned GREEN_MULT  = 4;

    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 1380;
    localparam int SETTLE_CYCLES  = 150;   // long enough for a full palette query
    localparam int HOLD_CYCLES    = 600;   // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
    localparam int REPORT_LIMIT   = 10;
    localparam int COLOUR_STEP    = (1 << COLOR_W) / PALETTE_DEPTH;
    localparam int MAX_COUNT      = (1 << CFG_W) - 1;

    // one result item
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
        logic               empty;
    } t_nearest;

    // per query: a hand-written answer, or none and the predictor decides
    typedef struct packed {
        logic     typed;
        t_nearest answer;
    } t_answer_hint;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_COUNT
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [IDX_W-1:0]   slot;
        logic [COLOR_W-1:0] colour;
        logic [CFG_W-1:0]   count;
        logic               typed;
        t_nearest           answer;
    } t_stim_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_SPARSE
    } t_rx_mode;

    // block ports
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    t_cmd               i_command     = CMD_LOAD;
    logic [IDX_W-1:0]   i_entry_index = '0;
    logic [COLOR_W-1:0] i_color_value = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [INDEX_W-1:0] o_best_index;
    logic [DIST_W-1:0]  o_best_distance;
    logic               o_palette_empty;

    // predictor state, updated at the accepting clock edges
    logic [COLOR_W-1:0] shadow_palette [PALETTE_DEPTH];
    int                 search_count = 0;
    t_nearest           pending_matches [$];
    t_answer_hint       answer_hints [$];
    int                 mismatches = 0;

    // sender side: what has been written, for building near-miss queries
    logic [COLOR_W-1:0] drv_palette [PALETTE_DEPTH];
    int                 burst_left = 0;
    t_stim_row          directed_rows [$];

    // receiver side
    int                 holds_asked  = 0;
    int                 holds_served = 0;
    int                 hold_left    = 0;
    int                 rx_left      = 0;
    t_rx_mode           rx_mode      = RX_ALWAYS;

    nearest_palette_color_redmean u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_entry_index   (i_entry_index),
        .i_color_value   (i_color_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance),
        .o_palette_empty (o_palette_empty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // integer redmean distance between two packed colours
    function automatic logic [DIST_W-1:0] colour_distance(logic [COLOR_W-1:0] a,
                                                          logic [COLOR_W-1:0] b);
        int unsigned ra, ga, ba, rb, gb, bb;
        int unsigned dr, dg, db, rmean, total;
        ra = a[23:16];
        ga = a[15:8];
        ba = a[7:0];
        rb = b[23:16];
        gb = b[15:8];
        bb = b[7:0];
        rmean = (ra + rb) >> 1;
        dr = (ra > rb) ? ra - rb : rb - ra;
        dg = (ga > gb) ? ga - gb : gb - ga;
        db = (ba > bb) ? ba - bb : bb - ba;
        total = (((RED_WEIGHT + rmean) * dr * dr) >> 8)
              + (GREEN_MULT * dg * dg)
              + (((BLUE_WEIGHT - rmean) * db * db) >> 8);
        return total[DIST_W-1:0];
    endfunction

    // scan from entry 0 upward, strict less-than so the lowest index wins a tie
    function automatic t_nearest predict_nearest(logic [COLOR_W-1:0] colour);
        t_nearest          best;
        int                span;
        logic [DIST_W-1:0] d;
        best = '0;
        // a count above the depth saturates
        span = (search_count > PALETTE_DEPTH) ? PALETTE_DEPTH : search_count;
        if (span == 0) begin
            best.empty = 1'b1;
            return best;
        end
        best.distance = colour_distance(colour, shadow_palette[0]);
        for (int i = 1; i < span; i++) begin
            d = colour_distance(colour, shadow_palette[i]);
            if (d < best.distance) begin
                best.distance = d;
                best.index    = i[INDEX_W-1:0];
            end
        end
        return best;
    endfunction

    // predictor and result check, all on values sampled at the clock edge
    always @(posedge i_clk) begin : scoreboard
        t_answer_hint hint;
        t_nearest     want;
        if (!i_rst_n) begin
            search_count = 0;
        end else begin
            if (i_cfg_we) begin
                search_count = int'(i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                if (i_command == CMD_LOAD) begin
                    shadow_palette[i_entry_index] = i_color_value;
                end else begin
                    hint = answer_hints.pop_front();
                    if (hint.typed) begin
                        pending_matches.push_back(hint.answer);
                    end else begin
                        pending_matches.push_back(predict_nearest(i_color_value));
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_matches.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t ns: result with nothing outstanding: index %0d distance %0d empty %0b",
                                 $time, o_best_index, o_best_distance, o_palette_empty);
                    end
                end else begin
                    want = pending_matches.pop_front();
                    if (o_best_index !== want.index || o_best_distance !== want.distance ||
                        o_palette_empty !== want.empty) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t ns: mismatch (expected/actual) index %0d/%0d distance %0d/%0d empty %0b/%0b",
                                     $time, want.index, o_best_index, want.distance,
                                     o_best_distance, want.empty, o_palette_empty);
                        end
                    end
                end
            end
        end
    end

    // receiver: stall pattern of its own, plus the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end else begin
                rx_left = rx_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS:       i_out_ready <= 1'b1;
                RX_COIN:         i_out_ready <= 1'($urandom_range(0, 1));
                RX_EVERY_FOURTH: i_out_ready <= (rx_left % 4 == 0);
                default:         i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // give up when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one item in bursts with random gaps, return at the accepting edge
    task automatic send_item(t_cmd cmd, int slot, int colour, bit typed, t_nearest answer);
        int           gap;
        t_answer_hint hint;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(8, 30);
            end else begin
                gap = $urandom_range(1, 3);
            end
            repeat (gap) @(posedge i_clk);
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(30, 80);
            end else begin
                burst_left = $urandom_range(1, 10);
            end
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= slot[IDX_W-1:0];
        i_color_value <= colour[COLOR_W-1:0];
        if (cmd == CMD_QUERY) begin
            hint.typed  = typed;
            hint.answer = answer;
            answer_hints.push_back(hint);
        end else begin
            drv_palette[slot] = colour[COLOR_W-1:0];
        end
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
    endtask

    // count write: only once the block has gone quiet
    task automatic program_count(int count);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_matches.size() != 0);
        // a trailing load gives no result, so allow a full query time as well
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        burst_left = 0;
    endtask

    task automatic add_row(t_row_kind kind, int slot, int colour, int count, bit typed,
                           int exp_index, int exp_dist, bit exp_empty);
        t_stim_row row;
        row.kind            = kind;
        row.slot            = slot[IDX_W-1:0];
        row.colour          = colour[COLOR_W-1:0];
        row.count           = count[CFG_W-1:0];
        row.typed           = typed;
        row.answer.index    = exp_index[INDEX_W-1:0];
        row.answer.distance = exp_dist[DIST_W-1:0];
        row.answer.empty    = exp_empty;
        directed_rows.push_back(row);
    endtask

    initial begin : stimulus
        t_stim_row row;
        int        phase, sent, count, span, n_items, pick, slot, colour, accum;

        // directed table: kind, slot, colour, count, typed, index, distance, empty
        // empty palette straight after reset, both colour extremes
        add_row(ROW_QUERY, 0,   24'h000000, 0, 1, 0, 0, 1);
        add_row(ROW_QUERY, 127, 24'hFFFFFF, 0, 1, 0, 0, 1);
        // black and white, a duplicate black for the tie, and the top slot
        add_row(ROW_LOAD,  0,   24'h000000, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD,  1,   24'hFFFFFF, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD,  2,   24'h000000, 0, 0, 0, 0, 0);
        add_row(ROW_LOAD,  127, 24'h808080, 0, 0, 0, 0, 0);
        // single entry searched
        add_row(ROW_COUNT, 0,   0,          1, 0, 0, 0, 0);
        add_row(ROW_QUERY, 5,   24'h000000, 0, 1, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'hFFFFFF, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'hFF0000, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'h00FF00, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'h0000FF, 0, 0, 0, 0, 0);
        // three entries: exact hits and two greys, the tie on black goes to the lower index
        add_row(ROW_COUNT, 0,   0,          3, 0, 0, 0, 0);
        add_row(ROW_QUERY, 64,  24'h000000, 0, 1, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'hFFFFFF, 0, 1, 1, 0, 0);
        add_row(ROW_QUERY, 0,   24'h7F7F7F, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'h808080, 0, 0, 0, 0, 0);
        // back to an empty search
        add_row(ROW_COUNT, 0,   0,          0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0,   24'h123456, 0, 1, 0, 0, 1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_COUNT: program_count(row.count);
                ROW_LOAD:  send_item(CMD_LOAD, row.slot, row.colour, 1'b0, '0);
                default:   send_item(CMD_QUERY, row.slot, row.colour, row.typed, row.answer);
            endcase
        end

        // fill the whole palette in ascending colour order, some repeats for ties
        sent  = 0;
        accum = 0;
        for (slot = 0; slot < PALETTE_DEPTH; slot++) begin
            if ($urandom_range(0, 9) != 0) begin
                accum += $urandom_range(1, 2 * COLOUR_STEP);
            end
            if (accum > 24'hFFFFFF) begin
                accum = 24'hFFFFFF;
            end
            send_item(CMD_LOAD, slot, accum, 1'b0, '0);
            sent++;
        end

        // phases: count written while quiet, then mostly queries with some reloads
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       count = PALETTE_DEPTH;
                1:       count = MAX_COUNT;
                2:       count = 0;
                3:       count = $urandom_range(PALETTE_DEPTH + 1, MAX_COUNT - 1);
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        count = 0;
                    end else if (pick == 1) begin
                        count = PALETTE_DEPTH;
                    end else if (pick == 2) begin
                        count = MAX_COUNT;
                    end else if (pick < 6) begin
                        count = $urandom_range(1, 16);
                    end else begin
                        count = $urandom_range(1, PALETTE_DEPTH);
                    end
                end
            endcase
            program_count(count);
            span = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;

            // receiver holds off while the sender keeps offering items
            if (phase % 9 == 4) begin
                holds_asked <= holds_asked + 1;
            end

            n_items = $urandom_range(20, 90);
            repeat (n_items) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    slot = $urandom_range(0, PALETTE_DEPTH - 1);
                    if (pick < 12) begin
                        colour = $urandom_range(0, 24'hFFFFFF);
                    end else begin
                        colour = drv_palette[slot] ^ ($urandom & 24'h070707);
                    end
                    send_item(CMD_LOAD, slot, colour, 1'b0, '0);
                end else begin
                    if (span == 0 || pick < 50) begin
                        colour = $urandom_range(0, 24'hFFFFFF);
                    end else if (pick < 70) begin
                        // exact hit, duplicates make ties
                        colour = drv_palette[$urandom_range(0, span - 1)];
                    end else begin
                        // near miss around a searched entry
                        colour = drv_palette[$urandom_range(0, span - 1)] ^
                                 ($urandom & 24'h0F0F0F);
                    end
                    send_item(CMD_QUERY, $urandom_range(0, PALETTE_DEPTH - 1), colour,
                              1'b0, '0);
                end
                sent++;
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/npc_pkg.sv
src/npc_palette_ram.sv
src/npc_distance_unit.sv
src/nearest_palette_color_redmean.sv
sim/tb_top.sv
